@@ design/crcp_pkg.sv @@
// Shared types and constants of the console register command parser.
`timescale 1ns / 1ps
package crcp_pkg;

  localparam int LINE_DEPTH_DEF = 32;
  localparam int MAG_W          = 17;

  localparam logic [MAG_W-1:0] MAG_CAP     = MAG_W'(100000);
  localparam logic [MAG_W-1:0] ADDR_MAX    = MAG_W'(64);
  localparam logic [MAG_W-1:0] IVL_MIN     = MAG_W'(100);
  localparam logic [MAG_W-1:0] IVL_MAX     = MAG_W'(5000);
  localparam logic [MAG_W-1:0] VAL_POS_MAX = MAG_W'(32767);
  localparam logic [MAG_W-1:0] VAL_NEG_MAX = MAG_W'(32768);

  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_S   = 8'h53;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_LO_T   = 8'h74;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_WRITE     = 4'd1,
    ST_READ      = 4'd2,
    ST_INTERVAL  = 4'd3,
    ST_NO_DOLLAR = 4'd4,
    ST_BAD_ADDR  = 4'd5,
    ST_ADDR_RNG  = 4'd6,
    ST_BAD_VALUE = 4'd7,
    ST_IVL_RNG   = 4'd8,
    ST_BAD_INT   = 4'd9,
    ST_UNKNOWN   = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CMD_S,
    CMD_R,
    CMD_T,
    CMD_X
  } cmd_t;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIG,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t           ph;
    logic [MAG_W-1:0] mag;
    logic             found;
    logic             neg;
  } fld_t;

  localparam fld_t FLD_CLR = '{ph: PH_BLANK, mag: '0, found: 1'b0, neg: 1'b0};

  function automatic cmd_t cmd_decode(logic [7:0] c);
    cmd_t k;
    k = CMD_X;
    if (c == CH_UP_S || c == CH_LO_S) k = CMD_S;
    else if (c == CH_UP_R || c == CH_LO_R) k = CMD_R;
    else if (c == CH_UP_T || c == CH_LO_T) k = CMD_T;
    return k;
  endfunction

  // one character of a decimal field: blanks, optional sign, digits
  function automatic fld_t fld_step(fld_t f, logic [7:0] c, logic allow_sign);
    fld_t        r;
    logic [20:0] acc;
    logic        is_dig;
    logic        is_blank;
    r        = f;
    is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
    acc      = ({4'd0, f.mag} << 3) + ({4'd0, f.mag} << 1) + {17'd0, c[3:0]};
    case (f.ph)
      PH_BLANK: begin
        if (is_blank) begin
          r.ph = PH_BLANK;
        end else if (allow_sign && (c == CH_MINUS || c == CH_PLUS)) begin
          r.neg = (c == CH_MINUS);
          r.ph  = PH_DIG;
        end else if (is_dig) begin
          r.mag   = (acc > {4'd0, MAG_CAP}) ? MAG_CAP : acc[MAG_W-1:0];
          r.found = 1'b1;
          r.ph    = PH_DIG;
        end else begin
          r.ph = PH_DONE;
        end
      end
      PH_DIG: begin
        if (is_dig) begin
          r.mag   = (acc > {4'd0, MAG_CAP}) ? MAG_CAP : acc[MAG_W-1:0];
          r.found = 1'b1;
        end else begin
          r.ph = PH_DONE;
        end
      end
      default: r.ph = PH_DONE;
    endcase
    return r;
  endfunction

endpackage

@@ design/crcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module crcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/console_register_command_parser.sv @@
// Console line buffer, echo and S/R/T command decoder (top level).
//
//   channel | dir | ports                                             | beat
//   in      | in  | in_valid, in_stall, in_rx_char                    | one character
//   out     | out | out_valid, out_stall, out_echo_en, out_echo_char, | one result per
//           |     | out_status, out_reg_addr, out_reg_value,          | character
//           |     | out_interval_ms                                   |
//
// An ordinary character is stored while the line has room; its result is loaded at accept.
// End of line with n stored characters: one memory read per stored character
// through the line RAM's single read port, then the status is formed in S_FIN.
// Empty line: its result is loaded at accept.
// Synchronous active-low reset clears the control state; line RAM is not cleared.
// Input is stalled while a line is scanned or while a held result is stalled.
`timescale 1ns / 1ps
module console_register_command_parser
  import crcp_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_echo_en,
  output logic [7:0]         out_echo_char,
  output logic [3:0]         out_status,
  output logic [6:0]         out_reg_addr,
  output logic signed [15:0] out_reg_value,
  output logic [12:0]        out_interval_ms
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] last_r, last_nxt;
  cmd_t          kind_r, kind_nxt;
  logic          dollar_r, dollar_nxt;
  fld_t          afld_r, afld_nxt;
  fld_t          vfld_r, vfld_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          echo_en_r, echo_en_nxt;
  logic [7:0]    echo_char_r, echo_char_nxt;
  status_t       status_r, status_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic [15:0]   value_r, value_nxt;
  logic [12:0]   ivl_r, ivl_nxt;

  logic          out_free;
  logic          in_acc;
  logic          is_eol;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          out_load;
  logic          scan_last;

  status_t       fin_status;
  logic [6:0]    fin_addr;
  logic [15:0]   fin_value;
  logic [12:0]   fin_ivl;

  crcp_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r),
    .wdata(in_rx_char),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign is_eol    = (in_rx_char == CH_CR) || (in_rx_char == CH_LF);
  assign scan_last = (pos_r == last_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && is_eol && fill_r != '0) state_nxt = S_SCAN;
      S_SCAN: if (scan_last) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        ram_we   = in_acc && !is_eol && (fill_r < FILL_MAX);
        out_load = in_acc && !(is_eol && fill_r != '0);
      end
      S_SCAN: ram_raddr = pos_r + AW'(1);
      S_FIN:  out_load = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // final status from the parse state
  always_comb begin
    fin_status = ST_UNKNOWN;
    fin_addr   = '0;
    fin_value  = '0;
    fin_ivl    = '0;
    case (kind_r)
      CMD_S: begin
        if (!dollar_r) fin_status = ST_NO_DOLLAR;
        else if (!afld_r.found) fin_status = ST_BAD_ADDR;
        else if (afld_r.mag > ADDR_MAX) fin_status = ST_ADDR_RNG;
        else if (!vfld_r.found) fin_status = ST_BAD_VALUE;
        else if (vfld_r.neg ? (vfld_r.mag > VAL_NEG_MAX) : (vfld_r.mag > VAL_POS_MAX))
          fin_status = ST_BAD_VALUE;
        else begin
          fin_status = ST_WRITE;
          fin_addr   = afld_r.mag[6:0];
          fin_value  = vfld_r.neg ? (16'd0 - vfld_r.mag[15:0]) : vfld_r.mag[15:0];
        end
      end
      CMD_R: begin
        if (!afld_r.found) fin_status = ST_BAD_ADDR;
        else if (afld_r.mag > ADDR_MAX) fin_status = ST_ADDR_RNG;
        else begin
          fin_status = ST_READ;
          fin_addr   = afld_r.mag[6:0];
        end
      end
      CMD_T: begin
        if (!afld_r.found) fin_status = ST_BAD_INT;
        else if (afld_r.mag < IVL_MIN || afld_r.mag > IVL_MAX) fin_status = ST_IVL_RNG;
        else begin
          fin_status = ST_INTERVAL;
          fin_ivl    = afld_r.mag[12:0];
        end
      end
      default: fin_status = ST_UNKNOWN;
    endcase
  end

  // datapath next values
  always_comb begin
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    kind_nxt   = kind_r;
    dollar_nxt = dollar_r;
    afld_nxt   = afld_r;
    vfld_nxt   = vfld_r;

    if (state_r == S_IDLE && in_acc) begin
      if (is_eol) begin
        fill_nxt = '0;
        pos_nxt  = '0;
        last_nxt = fill_r - AW'(1);
      end else if (fill_r < FILL_MAX) begin
        fill_nxt = fill_r + AW'(1);
      end
    end

    if (state_r == S_SCAN) begin
      pos_nxt = pos_r + AW'(1);
      if (pos_r == '0) begin
        kind_nxt   = cmd_decode(ram_rdata);
        dollar_nxt = 1'b0;
        afld_nxt   = FLD_CLR;
        vfld_nxt   = FLD_CLR;
      end else if (kind_r == CMD_S && !dollar_r && ram_rdata == CH_DOLLAR) begin
        dollar_nxt = 1'b1;
      end else if (!dollar_r) begin
        afld_nxt = fld_step(afld_r, ram_rdata, 1'b0);
      end else begin
        vfld_nxt = fld_step(vfld_r, ram_rdata, 1'b1);
      end
    end

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
    echo_en_nxt   = echo_en_r;
    echo_char_nxt = echo_char_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    ivl_nxt       = ivl_r;
    if (out_load) begin
      addr_nxt  = '0;
      value_nxt = '0;
      ivl_nxt   = '0;
      if (state_r == S_FIN) begin
        echo_en_nxt   = 1'b1;
        echo_char_nxt = CH_LF;
        status_nxt    = fin_status;
        addr_nxt      = fin_addr;
        value_nxt     = fin_value;
        ivl_nxt       = fin_ivl;
      end else if (is_eol) begin
        echo_en_nxt   = 1'b1;
        echo_char_nxt = CH_LF;
        status_nxt    = ST_NONE;
      end else begin
        echo_en_nxt   = (fill_r < FILL_MAX);
        echo_char_nxt = (fill_r < FILL_MAX) ? in_rx_char : 8'd0;
        status_nxt    = ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    kind_r      <= kind_nxt;
    dollar_r    <= dollar_nxt;
    afld_r      <= afld_nxt;
    vfld_r      <= vfld_nxt;
    echo_en_r   <= echo_en_nxt;
    echo_char_r <= echo_char_nxt;
    status_r    <= status_nxt;
    addr_r      <= addr_nxt;
    value_r     <= value_nxt;
    ivl_r       <= ivl_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_echo_en     = echo_en_r;
  assign out_echo_char   = echo_char_r;
  assign out_status      = status_r;
  assign out_reg_addr    = addr_r;
  assign out_reg_value   = value_r;
  assign out_interval_ms = ivl_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("line fill count beyond store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> pos_r <= last_r)
    else $error("scan position past end of line");

  a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> out_valid_r && status_r != ST_NONE && echo_en_r)
    else $error("end of line beat without status");

  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !echo_en_r |-> status_r == ST_NONE && echo_char_r == 8'd0)
    else $error("dropped character beat carries data");

endmodule
